// File: design/dti_pkg.sv
// ----------------------------------------------------------------------------
// dti_pkg: shared types and constants for decision tree inference
// Holds the node and feature entry layouts, store sizes, operation and
// status codes used by the stores and the walk sequencer.
// ----------------------------------------------------------------------------
package dti_pkg;

    // Store sizes and value width
    localparam int MAX_NODES    = 1024;
    localparam int MAX_FEATURES = 256;
    localparam int VALUE_WIDTH  = 32;

    localparam int NODE_IDX_W = $clog2(MAX_NODES);
    localparam int FEAT_IDX_W = $clog2(MAX_FEATURES);
    localparam int STEP_W     = $clog2(MAX_NODES + 1);

    // Field widths fixed by the interface
    localparam int NODE_FIELD_W = 10;
    localparam int FEAT_FIELD_W = 8;
    localparam int DATA_W       = 32;

    // Operation codes
    localparam logic [1:0] OP_NODE_WR = 2'd0;
    localparam logic [1:0] OP_FEAT_WR = 2'd1;
    localparam logic [1:0] OP_PREDICT = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_LIMIT = 2'd2;

    // One node store entry
    typedef struct packed {
        logic                    leaf;
        logic [FEAT_FIELD_W-1:0] feature;
        logic [DATA_W-1:0]       value;
        logic [NODE_FIELD_W-1:0] left;
        logic [NODE_FIELD_W-1:0] right;
    } node_entry_t;

    // One feature store entry
    typedef struct packed {
        logic              missing;
        logic [DATA_W-1:0] value;
    } feat_entry_t;

    // Read request from the sequencer to a store
    typedef struct packed {
        logic                    en;
        logic [NODE_IDX_W-1:0]   addr;
    } node_rd_t;

    typedef struct packed {
        logic                    en;
        logic [FEAT_IDX_W-1:0]   addr;
    } feat_rd_t;

    // Keep the low VALUE_WIDTH bits, sign extended to the full width
    function automatic logic [DATA_W-1:0] fit_value(input logic [DATA_W-1:0] raw);
        logic [DATA_W-1:0] res;
        res = raw;
        for (int i = VALUE_WIDTH; i < DATA_W; i++) begin
            res[i] = raw[VALUE_WIDTH-1];
        end
        return res;
    endfunction

endpackage

// File: design/dti_node_mem.sv
// ----------------------------------------------------------------------------
// dti_node_mem: node store
// Single write port, single registered read port. Contents are undefined
// until written.
// ----------------------------------------------------------------------------
module dti_node_mem
    import dti_pkg::*;
(
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [NODE_IDX_W-1:0] wr_addr,
    input  node_entry_t           wr_data,
    input  node_rd_t              rd_req,
    output node_entry_t           rd_data
);

    node_entry_t mem [MAX_NODES];
    node_entry_t rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_req.en) begin
            rd_data_reg <= mem[rd_req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/dti_feat_store.sv
// ----------------------------------------------------------------------------
// dti_feat_store: feature store
// Value memory with one flag per entry; an entry never written since reset
// reads as missing.
// ----------------------------------------------------------------------------
module dti_feat_store
    import dti_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [FEAT_IDX_W-1:0] wr_addr,
    input  feat_entry_t           wr_data,
    input  feat_rd_t              rd_req,
    output feat_entry_t           rd_data
);

    feat_entry_t             mem [MAX_FEATURES];
    logic [MAX_FEATURES-1:0] written_reg;
    feat_entry_t             rd_data_reg;
    logic                    rd_written_reg;

    // Value memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_req.en) begin
            rd_data_reg <= mem[rd_req.addr];
        end
    end

    // Written flags, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_req.en) begin
                rd_written_reg <= written_reg[rd_req.addr];
            end
        end
    end

    // Treat an unwritten entry as missing
    assign rd_data.missing = rd_data_reg.missing | ~rd_written_reg;
    assign rd_data.value   = rd_data_reg.value;

endmodule

// File: design/dti_walk.sv
// ----------------------------------------------------------------------------
// dti_walk: tree walk sequencer
// Steps through the tree one node at a time with a shared signed compare,
// counts moves against the step limit and holds the result register.
// ----------------------------------------------------------------------------
module dti_walk
    import dti_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_operation,
    output node_rd_t                node_rd,
    input  node_entry_t             node_data,
    output feat_rd_t                feat_rd,
    input  feat_entry_t             feat_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [DATA_W-1:0]       m_prediction,
    output logic [NODE_FIELD_W-1:0] m_leaf_reached,
    output logic [1:0]              m_status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_NODE = 2'd1;
    localparam logic [1:0] S_FEAT = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]              state_reg,    state_next;
    logic [NODE_IDX_W-1:0]   cur_reg,      cur_next;
    logic [STEP_W-1:0]       steps_reg,    steps_next;
    logic                    loaded_reg,   loaded_next;
    logic [DATA_W-1:0]       res_pred_reg, res_pred_next;
    logic [NODE_IDX_W-1:0]   res_leaf_reg, res_leaf_next;
    logic [1:0]              res_stat_reg, res_stat_next;
    logic                    m_valid_reg,  m_valid_next;
    logic [DATA_W-1:0]       m_pred_reg,   m_pred_next;
    logic [NODE_IDX_W-1:0]   m_leaf_reg,   m_leaf_next;
    logic [1:0]              m_stat_reg,   m_stat_next;

    logic                    accept;
    logic                    go_right;
    logic [NODE_FIELD_W-1:0] child;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid & s_ready;

    // Shared compare: missing or above threshold goes right
    assign go_right = feat_data.missing |
                      ~($signed(feat_data.value) <= $signed(node_data.value));
    assign child    = go_right ? node_data.right : node_data.left;

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        steps_next    = steps_reg;
        loaded_next   = loaded_reg;
        res_pred_next = res_pred_reg;
        res_leaf_next = res_leaf_reg;
        res_stat_next = res_stat_reg;
        m_valid_next  = m_valid_reg;
        m_pred_next   = m_pred_reg;
        m_leaf_next   = m_leaf_reg;
        m_stat_next   = m_stat_reg;
        node_rd       = '0;
        feat_rd       = '0;

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept && s_operation == OP_NODE_WR) begin
                    loaded_next = 1'b1;
                end
                if (accept && s_operation == OP_PREDICT) begin
                    if (!loaded_reg) begin
                        res_pred_next = '0;
                        res_leaf_next = '0;
                        res_stat_next = STAT_EMPTY;
                        state_next    = S_DONE;
                    end else begin
                        cur_next     = '0;
                        steps_next   = '0;
                        node_rd.en   = 1'b1;
                        node_rd.addr = '0;
                        state_next   = S_NODE;
                    end
                end
            end
            S_NODE: begin
                if (node_data.leaf) begin
                    res_pred_next = node_data.value;
                    res_leaf_next = cur_reg;
                    res_stat_next = STAT_OK;
                    state_next    = S_DONE;
                end else if (steps_reg >= STEP_W'(MAX_NODES)) begin
                    res_pred_next = '0;
                    res_leaf_next = '0;
                    res_stat_next = STAT_LIMIT;
                    state_next    = S_DONE;
                end else begin
                    feat_rd.en   = 1'b1;
                    feat_rd.addr = node_data.feature[FEAT_IDX_W-1:0];
                    state_next   = S_FEAT;
                end
            end
            S_FEAT: begin
                cur_next     = child[NODE_IDX_W-1:0];
                steps_next   = steps_reg + 1'b1;
                node_rd.en   = 1'b1;
                node_rd.addr = child[NODE_IDX_W-1:0];
                state_next   = S_NODE;
            end
            S_DONE: begin
                // Load the output register when it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_pred_next  = res_pred_reg;
                    m_leaf_next  = res_leaf_reg;
                    m_stat_next  = res_stat_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            loaded_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            loaded_reg  <= loaded_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Walk and result payload
    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        steps_reg    <= steps_next;
        res_pred_reg <= res_pred_next;
        res_leaf_reg <= res_leaf_next;
        res_stat_reg <= res_stat_next;
        m_pred_reg   <= m_pred_next;
        m_leaf_reg   <= m_leaf_next;
        m_stat_reg   <= m_stat_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_prediction   = m_pred_reg;
    assign m_leaf_reached = NODE_FIELD_W'(m_leaf_reg);
    assign m_status       = m_stat_reg;

endmodule

// File: design/decision_tree_inference_top.sv
// Predict: the walk does a node read and then a feature read for each
// node passed, and a node read for the leaf reached.
// Throughput: one transaction at a time; s_ready is high only while idle.
// An empty-tree predict goes to the done state and shows its result once the output register is free.
// Reset: synchronous, active low; clears the loaded flag, the feature
// written flags and the result valid. The node store is not cleared.
// ----------------------------------------------------------------------------
// decision_tree_inference_top: binary decision tree inference
// Node and feature writes fill the stores; a predict walks the tree from
// node 0 and returns the weight of the leaf reached.
// ----------------------------------------------------------------------------
module decision_tree_inference_top
    import dti_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_operation,
    input  logic [NODE_FIELD_W-1:0]        s_node_index,
    input  logic                           s_node_leaf,
    input  logic [FEAT_FIELD_W-1:0]        s_split_feature,
    input  logic signed [DATA_W-1:0]       s_split_threshold,
    input  logic [NODE_FIELD_W-1:0]        s_left_child,
    input  logic [NODE_FIELD_W-1:0]        s_right_child,
    input  logic signed [DATA_W-1:0]       s_leaf_weight,
    input  logic [FEAT_FIELD_W-1:0]        s_feature_index,
    input  logic signed [DATA_W-1:0]       s_feature_value,
    input  logic                           s_feature_missing,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [DATA_W-1:0]       m_prediction,
    output logic [NODE_FIELD_W-1:0]        m_leaf_reached,
    output logic [1:0]                     m_status
);

    logic        accept;
    logic        node_wr_en;
    logic        feat_wr_en;
    node_entry_t node_wr_data;
    feat_entry_t feat_wr_data;
    node_rd_t    node_rd;
    feat_rd_t    feat_rd;
    node_entry_t node_data;
    feat_entry_t feat_data;
    logic [DATA_W-1:0] pred;

    assign accept     = s_valid & s_ready;
    assign node_wr_en = accept && (s_operation == OP_NODE_WR);
    assign feat_wr_en = accept && (s_operation == OP_FEAT_WR);

    // Build the node entry; a leaf keeps only its weight
    always_comb begin
        node_wr_data      = '0;
        node_wr_data.leaf = s_node_leaf;
        if (s_node_leaf) begin
            node_wr_data.value = fit_value(s_leaf_weight);
        end else begin
            node_wr_data.feature = s_split_feature;
            node_wr_data.value   = fit_value(s_split_threshold);
            node_wr_data.left    = s_left_child;
            node_wr_data.right   = s_right_child;
        end
    end

    assign feat_wr_data.missing = s_feature_missing;
    assign feat_wr_data.value   = fit_value(s_feature_value);

    dti_node_mem u_node_mem (
        .aclk    (aclk),
        .wr_en   (node_wr_en),
        .wr_addr (s_node_index[NODE_IDX_W-1:0]),
        .wr_data (node_wr_data),
        .rd_req  (node_rd),
        .rd_data (node_data)
    );

    dti_feat_store u_feat_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (feat_wr_en),
        .wr_addr (s_feature_index[FEAT_IDX_W-1:0]),
        .wr_data (feat_wr_data),
        .rd_req  (feat_rd),
        .rd_data (feat_data)
    );

    dti_walk u_walk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .node_rd        (node_rd),
        .node_data      (node_data),
        .feat_rd        (feat_rd),
        .feat_data      (feat_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_prediction   (pred),
        .m_leaf_reached (m_leaf_reached),
        .m_status       (m_status)
    );

    assign m_prediction = $signed(pred);

endmodule

// File: design/dti_checker.sv
// ----------------------------------------------------------------------------
// dti_checker: port-level checks for decision tree inference
// Watches the top level ports and flags result and sequencing slips.
// ----------------------------------------------------------------------------
module dti_checker
    import dti_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic [1:0]              s_operation,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [DATA_W-1:0]       m_prediction,
    input logic [NODE_FIELD_W-1:0] m_leaf_reached,
    input logic [1:0]              m_status
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_prediction) &&
        $stable(m_leaf_reached) && $stable(m_status))
        else $error("result changed while stalled");

    // Failed walks carry zero payload
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STAT_EMPTY || m_status == STAT_LIMIT) |->
        m_prediction == '0 && m_leaf_reached == '0)
        else $error("failed walk carries payload");

    // Only defined status codes are shown
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == STAT_OK || m_status == STAT_EMPTY ||
        m_status == STAT_LIMIT)
        else $error("undefined status code");

    // A write transaction leaves the block ready in the next cycle
    a_write_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation != OP_PREDICT |=> s_ready)
        else $error("not ready after write");

    // A predict transaction occupies the block in the next cycle
    a_predict_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation == OP_PREDICT |=> !s_ready)
        else $error("ready during predict");

endmodule

bind decision_tree_inference_top dti_checker u_dti_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_operation    (s_operation),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_prediction   (m_prediction),
    .m_leaf_reached (m_leaf_reached),
    .m_status       (m_status)
);
